// ===== rtl/core/assert_macros.svh =====
// Assertion macros of the slew limiter RTL, used by sscl_engine.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SSCL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("%m: check failed");

// The condition must never be true at a clock edge outside reset.
`define SSCL_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("%m: forbidden condition seen");

`endif

// ===== rtl/core/sscl_pkg.sv =====
// Shared constants, types and helper functions of the servo slew limiter.
// Used by sscl_engine and multichannel_servo_slew_limiter; depends on nothing.
`default_nettype none

package sscl_pkg;

	localparam int CHANNELS    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int EMIT_N      = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;
	localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int POS_W  = 12;
	localparam int CH_W   = 4;
	localparam int FUNC_W = 2;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 2;

	localparam logic [POS_W-1:0] RESET_MIN  = 12'd205;
	localparam logic [POS_W-1:0] RESET_MAX  = 12'd410;
	localparam logic [POS_W-1:0] RESET_STEP = 12'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_POS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 2'd2;

	typedef enum logic [FUNC_W-1:0] {
		FN_SET_ONE = 2'd0,
		FN_SET_ALL = 2'd1,
		FN_TICK    = 2'd2,
		FN_QUERY   = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [CH_W-1:0]    channel;
		logic [POS_W-1:0]   value;
	} cmd_t;

	typedef struct packed {
		logic [CH_W-1:0]    out_channel;
		logic [POS_W-1:0]   position;
		logic               moved;
		logic               all_at_target;
		logic               last;
	} res_t;

	// If the bounds cross, values under lo get lo and all others get hi.
	function automatic logic [POS_W-1:0] clamp_pos(
		input logic [POS_W-1:0] v,
		input logic [POS_W-1:0] lo,
		input logic [POS_W-1:0] hi
	);
		logic [POS_W-1:0] r;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Moves cur toward tgt by at most step; the result never leaves [0, 4095].
	function automatic logic [POS_W-1:0] step_toward(
		input logic [POS_W-1:0] cur,
		input logic [POS_W-1:0] tgt,
		input logic [POS_W-1:0] step
	);
		logic [POS_W-1:0] up;
		logic [POS_W-1:0] dn;
		logic [POS_W-1:0] r;
		up = tgt - cur;
		dn = cur - tgt;
		if (tgt > cur) begin
			r = (up > step) ? cur + step : tgt;
		end else if (cur > tgt) begin
			r = (dn > step) ? cur - step : tgt;
		end else begin
			r = cur;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sscl_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stands alone; used by sscl_engine for the target and current position stores.
`default_nettype none

module sscl_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sscl_engine.sv =====
// Command sequencer of the slew limiter: walks the position stores, applies the step
// limit and produces result words. Depends on sscl_pkg, sscl_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sscl_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	input  wire sscl_pkg::cmd_t             cmd,
	output logic                            idle,
	input  wire logic [sscl_pkg::POS_W-1:0] max_step,
	output logic                            res_valid,
	output sscl_pkg::res_t                  res,
	input  wire logic                       res_ready
);

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_ONE_RD   = 10'b00_0000_0010,
		ST_ONE_WR   = 10'b00_0000_0100,
		ST_QRY_RD   = 10'b00_0000_1000,
		ST_QRY_OUT  = 10'b00_0001_0000,
		ST_WALK     = 10'b00_0010_0000,
		ST_WALK_END = 10'b00_0100_0000,
		ST_ALL_OUT  = 10'b00_1000_0000,
		ST_EMIT_RD  = 10'b01_0000_0000,
		ST_EMIT_OUT = 10'b10_0000_0000
	} state_t;

	localparam logic [sscl_pkg::IDX_W-1:0] LAST_IDX  =
		sscl_pkg::IDX_W'(sscl_pkg::CHANNELS - 1);
	localparam logic [sscl_pkg::IDX_W-1:0] EMIT_LAST =
		sscl_pkg::IDX_W'(sscl_pkg::EMIT_N - 1);

	state_t                            state_q;
	state_t                            state_nx;
	sscl_pkg::func_t                   func_q;
	logic [sscl_pkg::CH_W-1:0]         ch_q;
	logic [sscl_pkg::POS_W-1:0]        val_q;
	logic [sscl_pkg::IDX_W-1:0]        idx_q;
	logic [sscl_pkg::IDX_W-1:0]        ra_q;
	logic                              walk_s1;
	logic [sscl_pkg::IDX_W-1:0]        widx_s1;
	logic [sscl_pkg::CHANNELS-1:0]     tgt_vld_q;
	logic [sscl_pkg::CHANNELS-1:0]     cur_vld_q;
	logic [sscl_pkg::CHANNELS-1:0]     differ_q;
	logic [sscl_pkg::CHANNELS-1:0]     differ_nx;
	logic [sscl_pkg::CHANNELS-1:0]     moved_q;

	logic                              in_rng;
	logic [sscl_pkg::IDX_W-1:0]        ch_idx;
	logic                              rd_en;
	logic [sscl_pkg::IDX_W-1:0]        rd_addr;
	logic [sscl_pkg::POS_W-1:0]        tgt_ram;
	logic [sscl_pkg::POS_W-1:0]        cur_ram;
	logic [sscl_pkg::POS_W-1:0]        tgt_rd;
	logic [sscl_pkg::POS_W-1:0]        cur_rd;
	logic [sscl_pkg::POS_W-1:0]        new_pos;
	logic                              tgt_we;
	logic [sscl_pkg::IDX_W-1:0]        tgt_wa;
	logic                              cur_we;
	logic                              res_take;
	logic                              walk_tick;
	logic                              walk_all;

	assign in_rng    = 32'(ch_q) < 32'(sscl_pkg::CHANNELS);
	assign ch_idx    = sscl_pkg::IDX_W'(ch_q);
	assign idle      = (state_q == ST_IDLE);
	assign res_take  = res_valid && res_ready;
	assign walk_tick = walk_s1 && (func_q == sscl_pkg::FN_TICK);
	assign walk_all  = walk_s1 && (func_q == sscl_pkg::FN_SET_ALL);

	// Entries never written since reset read as the reset position.
	assign tgt_rd  = tgt_vld_q[ra_q] ? tgt_ram : sscl_pkg::RESET_MIN;
	assign cur_rd  = cur_vld_q[ra_q] ? cur_ram : sscl_pkg::RESET_MIN;
	assign new_pos = sscl_pkg::step_toward(cur_rd, tgt_rd, max_step);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		unique case (state_q)
			ST_WALK, ST_EMIT_RD: begin
				rd_en = 1'b1;
			end
			ST_ONE_RD, ST_QRY_RD: begin
				rd_en   = 1'b1;
				rd_addr = ch_idx;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		tgt_we = 1'b0;
		tgt_wa = widx_s1;
		if (walk_all) begin
			tgt_we = 1'b1;
		end else if ((state_q == ST_ONE_WR) && res_take && in_rng) begin
			tgt_we = 1'b1;
			tgt_wa = ch_idx;
		end
	end

	assign cur_we = walk_tick;

	always_comb begin
		differ_nx = differ_q;
		if (walk_all) begin
			differ_nx[widx_s1] = (cur_rd != val_q);
		end else if (walk_tick) begin
			differ_nx[widx_s1] = (new_pos != tgt_rd);
		end else if ((state_q == ST_ONE_WR) && in_rng) begin
			differ_nx[ch_idx] = (cur_rd != val_q);
		end
	end

	sscl_ram #(.WIDTH(sscl_pkg::POS_W), .DEPTH(sscl_pkg::CHANNELS)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (tgt_wa),
		.wdata (val_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (tgt_ram)
	);

	sscl_ram #(.WIDTH(sscl_pkg::POS_W), .DEPTH(sscl_pkg::CHANNELS)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (widx_s1),
		.wdata (new_pos),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (cur_ram)
	);

	always_comb begin
		res_valid         = 1'b0;
		res.out_channel   = ch_q;
		res.position      = val_q;
		res.moved         = 1'b0;
		res.all_at_target = ~|differ_nx;
		res.last          = 1'b1;
		unique case (state_q)
			ST_ONE_WR: begin
				res_valid = 1'b1;
			end
			ST_QRY_OUT: begin
				res_valid    = 1'b1;
				res.position = in_rng ? cur_rd : '0;
			end
			ST_ALL_OUT: begin
				res_valid       = 1'b1;
				res.out_channel = '0;
			end
			ST_EMIT_OUT: begin
				res_valid       = 1'b1;
				res.out_channel = sscl_pkg::CH_W'(idx_q);
				res.position    = cur_rd;
				res.moved       = moved_q[idx_q];
				res.last        = (idx_q == EMIT_LAST);
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.func)
						sscl_pkg::FN_SET_ONE: state_nx = ST_ONE_RD;
						sscl_pkg::FN_QUERY:   state_nx = ST_QRY_RD;
						default:              state_nx = ST_WALK;
					endcase
				end
			end
			ST_ONE_RD:   state_nx = ST_ONE_WR;
			ST_QRY_RD:   state_nx = ST_QRY_OUT;
			ST_WALK: begin
				if (idx_q == LAST_IDX) begin
					state_nx = ST_WALK_END;
				end
			end
			ST_WALK_END: begin
				state_nx = (func_q == sscl_pkg::FN_SET_ALL) ? ST_ALL_OUT : ST_EMIT_RD;
			end
			ST_EMIT_RD:  state_nx = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (res_take) begin
					state_nx = res.last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_ONE_WR, ST_QRY_OUT, ST_ALL_OUT: begin
				if (res_take) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			walk_s1   <= 1'b0;
			tgt_vld_q <= '0;
			cur_vld_q <= '0;
			differ_q  <= '0;
			idx_q     <= '0;
		end else begin
			state_q  <= state_nx;
			walk_s1  <= (state_q == ST_WALK);
			differ_q <= differ_nx;
			if (tgt_we) begin
				tgt_vld_q[tgt_wa] <= 1'b1;
			end
			if (cur_we) begin
				cur_vld_q[widx_s1] <= 1'b1;
			end
			if (idle || (state_q == ST_WALK_END)) begin
				idx_q <= '0;
			end else if ((state_q == ST_WALK) && (idx_q != LAST_IDX)) begin
				idx_q <= idx_q + 1'b1;
			end else if ((state_q == ST_EMIT_OUT) && res_take && !res.last) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		widx_s1 <= idx_q;
		if (rd_en) begin
			ra_q <= rd_addr;
		end
		if (walk_tick) begin
			moved_q[widx_s1] <= (new_pos != cur_rd);
		end
		if (idle && cmd_valid) begin
			func_q <= cmd.func;
			ch_q   <= cmd.channel;
			val_q  <= cmd.value;
		end
	end

	// The write stage only ever follows a read issued by the walk.
	`SSCL_ASSERT(a_s1_from_walk, walk_s1 |-> $past(state_q == ST_WALK))
	// Nothing of a walk is still in flight once the engine reports idle.
	`SSCL_ASSERT(a_idle_drained, idle |-> !walk_s1)
	// The final result of a tick returns the engine to idle.
	`SSCL_ASSERT(a_emit_ends, (state_q == ST_EMIT_OUT && res_take && res.last) |=> idle)
	// A position entry is never read in the cycle it is rewritten.
	`SSCL_NEVER(a_cur_rw_clash, cur_we && rd_en && (widx_s1 == rd_addr))
	`SSCL_NEVER(a_tgt_rw_clash, tgt_we && rd_en && (tgt_wa == rd_addr))

endmodule

`default_nettype wire

// ===== rtl/core/multichannel_servo_slew_limiter.sv =====
// Top level of the multichannel servo slew limiter: configuration registers,
// input clamp and output register. Depends on sscl_pkg and sscl_engine.
`default_nettype none

// Usage
// Commands enter on the s_axis channel: tuser carries the command kind (set one
// target, set all targets, tick, query), tdata the channel and the requested width.
// Results leave on the m_axis channel, one word per result; tlast marks the final
// word of a command. Set and query commands give one word, a tick gives one word
// per channel in channel order (at most sixteen).
// The configuration channel writes min_position, max_position and max_step by
// index; it is always ready and must only be used while no command is in flight.
// Sequencing: the block handles one command at a time. Set-one and query read the
// position memories once and then give their word; set-all makes one walk over the
// memories that writes every target; a tick makes one walk that applies the step,
// then one memory read per reported word. Results are held in an output register,
// so a new command is taken while the last word still waits.
// When the receiver stalls the sequencer waits with the pending word and resumes
// when the output register frees up. Reset restores the configuration defaults and
// makes every target and current position read as the reset minimum at once.

module multichannel_servo_slew_limiter (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// [3:0] channel, [15:4] ticks
	input  wire logic [sscl_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// [1:0] func
	input  wire logic [sscl_pkg::FUNC_W-1:0]           s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// [3:0] out_channel, [15:4] position, [16] moved, [17] all_at_target,
	// [23:18] zero
	output logic [sscl_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
	output logic                                       m_axis_tlast,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [sscl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [sscl_pkg::POS_W-1:0]            cfg_data
);

	logic [sscl_pkg::POS_W-1:0] min_q;
	logic [sscl_pkg::POS_W-1:0] max_q;
	logic [sscl_pkg::POS_W-1:0] step_q;
	sscl_pkg::cmd_t             cmd;
	logic                       eng_idle;
	logic                       res_valid;
	sscl_pkg::res_t             res;
	logic                       slot_free;
	logic                       out_vld_q;
	sscl_pkg::res_t             out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= sscl_pkg::RESET_MIN;
			max_q  <= sscl_pkg::RESET_MAX;
			step_q <= sscl_pkg::RESET_STEP;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sscl_pkg::CFG_MIN_POS:  min_q  <= cfg_data;
				sscl_pkg::CFG_MAX_POS:  max_q  <= cfg_data;
				sscl_pkg::CFG_MAX_STEP: step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The requested width is clamped on entry, so the engine only sees legal targets.
	assign cmd.func    = sscl_pkg::func_t'(s_axis_tuser);
	assign cmd.channel = s_axis_tdata[sscl_pkg::CH_W-1:0];
	assign cmd.value   = sscl_pkg::clamp_pos(
		s_axis_tdata[sscl_pkg::CH_W +: sscl_pkg::POS_W], min_q, max_q);

	assign s_axis_tready = eng_idle;

	sscl_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_axis_tvalid),
		.cmd       (cmd),
		.idle      (eng_idle),
		.max_step  (step_q),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (slot_free)
	);

	// Single output register: it accepts a new word whenever it is empty or being drained.
	assign slot_free = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (slot_free) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tdata  = {
		6'd0, out_q.all_at_target, out_q.moved, out_q.position, out_q.out_channel
	};

endmodule

`default_nettype wire

// ===== test/tb_multichannel_servo_slew_limiter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multichannel_servo_slew_limiter: streams servo commands,
// reprograms the position window and step limit between phases, and checks each result
// word against a shadow copy of the servo positions. Depends on sscl_pkg and the RTL.

module tb_multichannel_servo_slew_limiter;
	import sscl_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 7;
	localparam int CYCLE_LIMIT   = 400000;
	// A set or query never leaves the block silent, so a short pause after the last
	// word is enough before touching the registers.
	localparam int SETTLE_CYCLES = 8;
	// Extra wait after the last owed word, to catch stray words at the end.
	localparam int TAIL_CYCLES   = 64;
	localparam int PHASE_ITEMS   = 13;
	localparam int DIRECTED_ROWS = 21;
	// The one index that maps to no register; writing it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// One command row: the command itself plus, where it is obvious, the position and
	// settled flag of its single result word.
	typedef struct packed {
		func_t              op;
		logic [CH_W-1:0]    ch;
		logic [POS_W-1:0]   ticks;
		logic               typed;
		logic [POS_W-1:0]   want_pos;
		logic               want_settled;
	} cmd_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata;
	logic [FUNC_W-1:0]       s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    m_axis_tlast;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [POS_W-1:0]        cfg_data;

	// Shadow of the block: window, step limit and both position stores.
	logic [POS_W-1:0] win_lo;
	logic [POS_W-1:0] win_hi;
	logic [POS_W-1:0] step_cap;
	logic [POS_W-1:0] shadow_target [CHANNELS];
	logic [POS_W-1:0] shadow_current [CHANNELS];

	// Result words still owed by the block, oldest first.
	res_t report_fifo [$];

	int error_count = 0;
	int cycle_count = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	// Directed commands at the reset window [205, 410] and step 6. Positions after the
	// ticks are left to the shadow model; the rest can be read straight off the clamp.
	cmd_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{FN_QUERY,   4'd0,  12'd0,    1'b1, 12'd205, 1'b1},
		'{FN_QUERY,   4'd15, 12'd4095, 1'b1, 12'd205, 1'b1},
		'{FN_SET_ONE, 4'd3,  12'd0,    1'b1, 12'd205, 1'b1},
		'{FN_SET_ONE, 4'd15, 12'd4095, 1'b1, 12'd410, 1'b0},
		'{FN_SET_ONE, 4'd0,  12'd300,  1'b1, 12'd300, 1'b0},
		'{FN_TICK,    4'd0,  12'd0,    1'b0, 12'd0,   1'b0},
		'{FN_QUERY,   4'd15, 12'd0,    1'b0, 12'd0,   1'b0},
		'{FN_SET_ONE, 4'd9,  12'd410,  1'b1, 12'd410, 1'b0},
		'{FN_SET_ONE, 4'd10, 12'd205,  1'b1, 12'd205, 1'b0},
		'{FN_SET_ALL, 4'd5,  12'd4095, 1'b1, 12'd410, 1'b0},
		'{FN_TICK,    4'd0,  12'd0,    1'b0, 12'd0,   1'b0},
		'{FN_TICK,    4'd0,  12'd0,    1'b0, 12'd0,   1'b0},
		'{FN_SET_ALL, 4'd0,  12'd0,    1'b1, 12'd205, 1'b0},
		'{FN_TICK,    4'd0,  12'd0,    1'b0, 12'd0,   1'b0},
		'{FN_TICK,    4'd0,  12'd0,    1'b0, 12'd0,   1'b0},
		'{FN_TICK,    4'd0,  12'd0,    1'b0, 12'd0,   1'b0},
		'{FN_QUERY,   4'd7,  12'd0,    1'b1, 12'd205, 1'b1},
		'{FN_SET_ONE, 4'd12, 12'd2047, 1'b1, 12'd410, 1'b0},
		'{FN_TICK,    4'd0,  12'd0,    1'b0, 12'd0,   1'b0},
		'{FN_QUERY,   4'd12, 12'd0,    1'b0, 12'd0,   1'b0},
		'{FN_SET_ONE, 4'd12, 12'd205,  1'b0, 12'd0,   1'b0}
	};

	multichannel_servo_slew_limiter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** multichannel_servo_slew_limiter: FAILED **");
			$finish;
		end
	end

	// If the bounds cross, values under win_lo get it and all others win_hi.
	function automatic logic [POS_W-1:0] fit_window(input logic [POS_W-1:0] v);
		if (v < win_lo)
			return win_lo;
		if (v > win_hi)
			return win_hi;
		return v;
	endfunction

	function automatic logic all_settled();
		for (int i = 0; i < CHANNELS; i++)
			if (shadow_current[i] != shadow_target[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Updates the shadow stores for one accepted command and queues the words it owes.
	task automatic apply_command(input func_t op, input logic [CH_W-1:0] ch,
			input logic [POS_W-1:0] ticks);
		res_t w;
		int diff;
		int cap;
		logic [CHANNELS-1:0] stepped;
		logic [POS_W-1:0] fitted;
		w = '0;
		case (op)
			FN_SET_ONE: begin
				fitted = fit_window(ticks);
				if (int'(ch) < CHANNELS)
					shadow_target[ch] = fitted;
				w.out_channel = ch;
				w.position = fitted;
				w.all_at_target = all_settled();
				w.last = 1'b1;
				report_fifo.push_back(w);
			end
			FN_SET_ALL: begin
				fitted = fit_window(ticks);
				for (int i = 0; i < CHANNELS; i++)
					shadow_target[i] = fitted;
				w.position = fitted;
				w.all_at_target = all_settled();
				w.last = 1'b1;
				report_fifo.push_back(w);
			end
			FN_TICK: begin
				// Every channel moves by the distance to its target, capped at the step
				// limit in either direction; a zero limit freezes all of them.
				cap = int'(step_cap);
				for (int i = 0; i < CHANNELS; i++) begin
					diff = int'(shadow_target[i]) - int'(shadow_current[i]);
					if (diff > cap)
						diff = cap;
					else if (diff < -cap)
						diff = -cap;
					shadow_current[i] = shadow_current[i] + diff[POS_W-1:0];
					stepped[i] = (diff != 0);
				end
				for (int i = 0; i < EMIT_N; i++) begin
					w.out_channel = CH_W'(i);
					w.position = shadow_current[i];
					w.moved = stepped[i];
					w.all_at_target = all_settled();
					w.last = (i == EMIT_N - 1);
					report_fifo.push_back(w);
				end
			end
			default: begin
				w.out_channel = ch;
				w.position = (int'(ch) < CHANNELS) ? shadow_current[ch] : '0;
				w.all_at_target = all_settled();
				w.last = 1'b1;
				report_fifo.push_back(w);
			end
		endcase
	endtask

	// Offers one command word after a random gap and waits until the block takes it.
	task automatic send_command(input cmd_row_t row);
		int gap;
		res_t w;
		gap = send_calm ? 0 : $urandom_range(0, 15);
		if ($urandom_range(0, 19) == 0)
			send_calm = !send_calm;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= row.op;
		s_axis_tdata <= {row.ticks, row.ch};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		apply_command(row.op, row.ch, row.ticks);
		if (row.typed) begin
			// Hand-written rows replace the model's figures for their single word.
			w = report_fifo.pop_back();
			w.position = row.want_pos;
			w.all_at_target = row.want_settled;
			report_fifo.push_back(w);
		end
		@(negedge clk);
	endtask

	// Leaves cfg_valid high so back-to-back writes follow without a gap; the caller
	// lowers it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			CFG_MIN_POS:  win_lo = val;
			CFG_MAX_POS:  win_hi = val;
			CFG_MAX_STEP: step_cap = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Registers may only change while no command is in flight.
	task automatic set_window(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
			input logic [POS_W-1:0] step, input bit poke_spare);
		s_axis_tvalid <= 1'b0;
		while (report_fifo.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(CFG_MIN_POS, lo);
		write_reg(CFG_MAX_POS, hi);
		write_reg(CFG_MAX_STEP, step);
		if (poke_spare)
			write_reg(CFG_SPARE, POS_W'($urandom_range(0, 4095)));
		cfg_valid <= 1'b0;
	endtask

	// Random commands; requested widths favor the window edges so both clamps and the
	// exact bounds come up often.
	task automatic run_random(input int count);
		cmd_row_t row;
		int pick;
		for (int n = 0; n < count; n++) begin
			row = '0;
			pick = $urandom_range(0, 99);
			if (pick < 30)
				row.op = FN_SET_ONE;
			else if (pick < 45)
				row.op = FN_SET_ALL;
			else if (pick < 80)
				row.op = FN_TICK;
			else
				row.op = FN_QUERY;
			row.ch = CH_W'($urandom_range(0, CHANNELS - 1));
			case ($urandom_range(0, 3))
				0: row.ticks = win_lo + POS_W'($urandom_range(0, 2)) - POS_W'(1);
				1: row.ticks = win_hi + POS_W'($urandom_range(0, 2)) - POS_W'(1);
				default: row.ticks = POS_W'($urandom_range(0, 4095));
			endcase
			send_command(row);
		end
	endtask

	task automatic compare_field(input string name, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// Result side: stalls a random number of cycles per word, with calm stretches, and
	// checks each accepted word against the oldest owed word.
	initial begin
		res_t want;
		res_t got;
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = recv_calm ? 0 : $urandom_range(0, 15);
			if ($urandom_range(0, 29) == 0)
				recv_calm = !recv_calm;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			got.out_channel = m_axis_tdata[CH_W-1:0];
			got.position = m_axis_tdata[CH_W +: POS_W];
			got.moved = m_axis_tdata[CH_W + POS_W];
			got.all_at_target = m_axis_tdata[CH_W + POS_W + 1];
			got.last = m_axis_tlast;
			if (report_fifo.size() == 0) begin
				$display("%0t: unexpected word, expected none, got channel %0d position %0d",
					$time, got.out_channel, got.position);
				error_count++;
			end else begin
				want = report_fifo.pop_front();
				compare_field("out_channel", POS_W'(want.out_channel),
					POS_W'(got.out_channel));
				compare_field("position", want.position, got.position);
				compare_field("moved", POS_W'(want.moved), POS_W'(got.moved));
				compare_field("all_at_target", POS_W'(want.all_at_target),
					POS_W'(got.all_at_target));
				compare_field("last", POS_W'(want.last), POS_W'(got.last));
			end
			@(negedge clk);
		end
	end

	initial begin
		logic [POS_W-1:0] lo;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		win_lo = RESET_MIN;
		win_hi = RESET_MAX;
		step_cap = RESET_STEP;
		for (int i = 0; i < CHANNELS; i++) begin
			shadow_target[i] = RESET_MIN;
			shadow_current[i] = RESET_MIN;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			send_command(directed_rows[r]);

		// Full range with an unlimited step: every channel jumps straight to its target.
		set_window(12'd0, 12'd4095, 12'd4095, 1'b0);
		run_random(PHASE_ITEMS);
		// Smallest nonzero step.
		set_window(12'd0, 12'd4095, 12'd1, 1'b0);
		run_random(PHASE_ITEMS);
		// Crossed bounds and a frozen step; the unmapped index is poked here too.
		set_window(12'd3000, 12'd1000, 12'd0, 1'b1);
		run_random(PHASE_ITEMS);
		set_window(12'd100, 12'd3000, 12'd37, 1'b0);
		run_random(PHASE_ITEMS);
		// Bounds crossed at the extremes: 4095 passes the low test and lands on zero.
		set_window(12'd4095, 12'd0, 12'd4095, 1'b0);
		run_random(PHASE_ITEMS);
		lo = POS_W'($urandom_range(0, 2000));
		set_window(lo, lo + POS_W'($urandom_range(0, 2000)), POS_W'($urandom_range(1, 64)),
			1'b0);
		run_random(PHASE_ITEMS);

		s_axis_tvalid <= 1'b0;
		while (report_fifo.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("** multichannel_servo_slew_limiter: PASSED **");
		else
			$display("** multichannel_servo_slew_limiter: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sscl_pkg.sv
rtl/core/sscl_ram.sv
rtl/core/sscl_engine.sv
rtl/core/multichannel_servo_slew_limiter.sv
test/tb_multichannel_servo_slew_limiter.sv
